// ===== hw/rtl/lcdrb_pkg.sv =====
// Shared constants, codes and transaction types for the LCD refresh buffer.
`timescale 1ns / 1ps

package lcdrb_pkg;

  // Panel geometry.
  localparam int NUM_COLS = 16;
  localparam int NUM_ROWS = 2;
  localparam int CELLS    = NUM_COLS * NUM_ROWS;
  localparam int ADDR_W   = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int COL_W    = $clog2(NUM_COLS + 1);
  localparam int ROW_W    = $clog2(NUM_ROWS);

  // Character values that the buffers hold after reset.
  localparam logic [7:0] SPACE_CHAR  = 8'h20;
  localparam logic [7:0] SHOWN_RESET = 8'h00;

  // Operation selectors.
  localparam logic [2:0] FN_SET_CURSOR   = 3'd0;
  localparam logic [2:0] FN_PUT_CHAR     = 3'd1;
  localparam logic [2:0] FN_CLR_ALL      = 3'd2;
  localparam logic [2:0] FN_CLR_BUT_FIRST = 3'd3;
  localparam logic [2:0] FN_CLR_BUT_LAST = 3'd4;
  localparam logic [2:0] FN_REFRESH      = 3'd5;

  // Panel command kinds.
  localparam logic CMD_SET_LOC = 1'b0;
  localparam logic CMD_WRITE   = 1'b1;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] char_code;
    logic       lcd_busy;
  } in_item_t;

  typedef struct packed {
    logic       cmd_kind;
    logic [3:0] cmd_col;
    logic       cmd_row;
    logic [7:0] cmd_char;
  } out_item_t;

  // Requests from the controller to the frame memories.
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              disp_we;
    logic [ADDR_W-1:0] disp_waddr;
    logic [7:0]        disp_wdata;
    logic              shown_we;
    logic [ADDR_W-1:0] shown_waddr;
    logic [7:0]        shown_wdata;
    logic [CELLS-1:0]  disp_clr;
  } mem_req_t;

  // Registered read data, already merged with the entry valid bits.
  typedef struct packed {
    logic [7:0] disp_data;
    logic [7:0] shown_data;
  } mem_rsp_t;

endpackage

// ===== hw/rtl/lcdrb_frame_mem.sv =====
// Display and shown frame memories with per-entry valid bits.
`timescale 1ns / 1ps

module lcdrb_frame_mem (
  input  logic              clk,
  input  logic              rst_n,
  input  lcdrb_pkg::mem_req_t req,
  output lcdrb_pkg::mem_rsp_t rsp
);
  import lcdrb_pkg::*;

  logic [7:0]       disp_mem  [CELLS];
  logic [7:0]       shown_mem [CELLS];
  logic [CELLS-1:0] disp_vld_r;
  logic [CELLS-1:0] disp_vld_nxt;
  logic [CELLS-1:0] shown_vld_r;
  logic [CELLS-1:0] shown_vld_nxt;
  logic [7:0]       rd_disp_r;
  logic [7:0]       rd_shown_r;
  logic             rd_dv_r;
  logic             rd_sv_r;

  // Memory arrays: one write port each, a shared read address and registered read data.
  always_ff @(posedge clk) begin
    if (req.disp_we) begin
      disp_mem[req.disp_waddr] <= req.disp_wdata;
    end
    if (req.shown_we) begin
      shown_mem[req.shown_waddr] <= req.shown_wdata;
    end
    if (req.rd_en) begin
      rd_disp_r  <= disp_mem[req.rd_addr];
      rd_shown_r <= shown_mem[req.rd_addr];
      rd_dv_r    <= disp_vld_r[req.rd_addr];
      rd_sv_r    <= shown_vld_r[req.rd_addr];
    end
  end

  // An entry becomes valid on a write; a clear drops display entries back
  // to their reset value of a space.
  always_comb begin
    disp_vld_nxt  = disp_vld_r & ~req.disp_clr;
    shown_vld_nxt = shown_vld_r;
    if (req.disp_we) begin
      disp_vld_nxt[req.disp_waddr] = 1'b1;
    end
    if (req.shown_we) begin
      shown_vld_nxt[req.shown_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disp_vld_r  <= '0;
      shown_vld_r <= '0;
    end else begin
      disp_vld_r  <= disp_vld_nxt;
      shown_vld_r <= shown_vld_nxt;
    end
  end

  // Entries that were never written read as their reset value.
  assign rsp.disp_data  = rd_dv_r ? rd_disp_r : SPACE_CHAR;
  assign rsp.shown_data = rd_sv_r ? rd_shown_r : SHOWN_RESET;

endmodule

// ===== hw/rtl/lcdrb_ctrl.sv =====
// Cursor, scan and command sequencer that drives the frame memories.
`timescale 1ns / 1ps

module lcdrb_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lcdrb_pkg::in_item_t  in_data,
  output logic                 res_valid,
  input  logic                 res_ready,
  output lcdrb_pkg::out_item_t res_data,
  output lcdrb_pkg::mem_req_t  mem_req,
  input  lcdrb_pkg::mem_rsp_t  mem_rsp
);
  import lcdrb_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EVAL = 1'b1;

  logic             state_r, state_nxt;
  logic [7:0]       cur_col_r, cur_col_nxt;
  logic [7:0]       cur_row_r, cur_row_nxt;
  logic [COL_W-1:0] scan_col_r, scan_col_nxt;
  logic [ROW_W-1:0] scan_row_r, scan_row_nxt;
  logic             addr_flag_r, addr_flag_nxt;

  logic             accept;
  logic             put_ok;
  logic [7:0]       col_inc;
  logic             scan_wrap;
  logic [ROW_W-1:0] row_inc;
  logic [CELLS-1:0] mask_all;
  logic [CELLS-1:0] mask_but_first;
  logic [CELLS-1:0] mask_but_last;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  assign put_ok    = (cur_col_r < 8'(NUM_COLS)) && (cur_row_r < 8'(NUM_ROWS));
  assign col_inc   = cur_col_r + 8'd1;
  assign scan_wrap = (scan_col_r == COL_W'(NUM_COLS));
  assign row_inc   = (scan_row_r == ROW_W'(NUM_ROWS - 1)) ? '0 : scan_row_r + 1'b1;

  // Row masks for the three clear operations.
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        mask_all[r * NUM_COLS + c]       = 1'b1;
        mask_but_first[r * NUM_COLS + c] = (r >= 1);
        mask_but_last[r * NUM_COLS + c]  = (r < NUM_ROWS - 1);
      end
    end
  end

  // Edits take effect when accepted; a refresh tick reads its scan cell and is
  // evaluated in the following cycle.
  always_comb begin
    state_nxt     = state_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    scan_col_nxt  = scan_col_r;
    scan_row_nxt  = scan_row_r;
    addr_flag_nxt = addr_flag_r;
    mem_req       = '0;
    mem_req.rd_addr     = ADDR_W'(int'(scan_row_r) * NUM_COLS + int'(scan_col_r));
    mem_req.disp_waddr  = ADDR_W'(int'(cur_row_r) * NUM_COLS + int'(cur_col_r));
    mem_req.disp_wdata  = in_data.char_code;
    mem_req.shown_waddr = mem_req.rd_addr;
    mem_req.shown_wdata = mem_rsp.disp_data;
    res_valid     = 1'b0;
    res_data      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_data.func)
            FN_SET_CURSOR: begin
              cur_col_nxt = in_data.pos_x;
              cur_row_nxt = in_data.pos_y;
            end
            FN_PUT_CHAR: begin
              if (put_ok) begin
                mem_req.disp_we = 1'b1;
                if (col_inc == 8'(NUM_COLS)) begin
                  cur_col_nxt = '0;
                  cur_row_nxt = (cur_row_r == 8'(NUM_ROWS - 1)) ? '0 : cur_row_r + 8'd1;
                end else begin
                  cur_col_nxt = col_inc;
                end
              end
            end
            FN_CLR_ALL: begin
              mem_req.disp_clr = mask_all;
              cur_col_nxt      = '0;
              cur_row_nxt      = '0;
            end
            FN_CLR_BUT_FIRST: begin
              mem_req.disp_clr = mask_but_first;
              cur_col_nxt      = '0;
              cur_row_nxt      = '0;
            end
            FN_CLR_BUT_LAST: begin
              mem_req.disp_clr = mask_but_last;
              cur_col_nxt      = '0;
              cur_row_nxt      = '0;
            end
            FN_REFRESH: begin
              if (!in_data.lcd_busy) begin
                mem_req.rd_en = !scan_wrap;
                state_nxt     = ST_EVAL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_EVAL: begin
        if (scan_wrap) begin
          // Row wrap: address the start of the next row.
          res_valid        = 1'b1;
          res_data.cmd_kind = CMD_SET_LOC;
          res_data.cmd_row = 1'(row_inc);
          if (res_ready) begin
            scan_col_nxt = '0;
            scan_row_nxt = row_inc;
            state_nxt    = ST_IDLE;
          end
        end else if (mem_rsp.disp_data != mem_rsp.shown_data) begin
          res_valid = 1'b1;
          if (!addr_flag_r) begin
            // First changed cell of a run: set the panel address.
            res_data.cmd_kind = CMD_SET_LOC;
            res_data.cmd_col  = 4'(scan_col_r);
            res_data.cmd_row  = 1'(scan_row_r);
            if (res_ready) begin
              addr_flag_nxt = 1'b1;
              state_nxt     = ST_IDLE;
            end
          end else begin
            // Write the character and record it as shown.
            res_data.cmd_kind = CMD_WRITE;
            res_data.cmd_char = mem_rsp.disp_data;
            if (res_ready) begin
              mem_req.shown_we = 1'b1;
              scan_col_nxt     = scan_col_r + 1'b1;
              state_nxt        = ST_IDLE;
            end
          end
        end else begin
          // Unchanged cell ends any run.
          addr_flag_nxt = 1'b0;
          scan_col_nxt  = scan_col_r + 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      scan_col_r  <= '0;
      scan_row_r  <= '0;
      addr_flag_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      scan_col_r  <= scan_col_nxt;
      scan_row_r  <= scan_row_nxt;
      addr_flag_r <= addr_flag_nxt;
    end
  end

endmodule

// ===== hw/rtl/char_lcd_diff_refresh_buffer_core.sv =====
// Top level of the character LCD refresh buffer with its output register.
//
// Usage: edit transactions (set cursor, put char, the three clears) and
// refresh ticks arrive on the in_ channel; panel commands leave on the
// out_ channel, at most one per refresh tick.
// Timing: an edit is applied when it is accepted and the block stays ready
// for the next one. A refresh tick that is not busy reads its scan cell from
// the frame memories (registered read data) and is evaluated in the following
// cycle; no new transaction is taken until that evaluation completes. Its
// command appears on out_valid the cycle after evaluation. Clears act on
// per-entry valid bits and are applied like any other edit.
// Reset: the display frame reads as all spaces, the shown frame as all
// zero (forcing a full repaint), cursor and scan position return to the
// top left corner. No memory sweep is needed after reset.
// Stall: a command waiting in the output register does not block new
// transactions; only a refresh tick that must emit while the register is
// still full waits in evaluation until out_ready frees it.
`timescale 1ns / 1ps

module char_lcd_diff_refresh_buffer_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lcdrb_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lcdrb_pkg::out_item_t out_data
);
  import lcdrb_pkg::*;

  mem_req_t  mem_req;
  mem_rsp_t  mem_rsp;
  logic      res_valid;
  logic      res_ready;
  out_item_t res_data;
  logic      out_valid_r;
  out_item_t out_data_r;

  lcdrb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .mem_req   (mem_req),
    .mem_rsp   (mem_rsp)
  );

  lcdrb_frame_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mem_req),
    .rsp   (mem_rsp)
  );

  // Output register: takes a new command when empty or being drained.
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the character LCD refresh buffer core.
`timescale 1ns / 1ps

module testbench;
  import lcdrb_pkg::*;

  // Selectors that the block must ignore.
  localparam logic [2:0] FN_UNUSED_LO = 3'd6;
  localparam logic [2:0] FN_UNUSED_HI = 3'd7;

  localparam int RANDOM_ITEMS     = 1625;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT   = 3000;
  localparam int DRAIN_CYCLES     = 8;
  localparam int REPORT_LIMIT     = 30;

  typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_COIN} rx_pattern_e;

  // Predicts the panel command stream and checks it against the block output.
  class lcd_cmd_scoreboard;
    logic [7:0]  frame_buf [CELLS];
    logic [7:0]  panel_copy [CELLS];
    logic [7:0]  cur_col;
    logic [7:0]  cur_row;
    int unsigned scan_c;
    int unsigned scan_r;
    bit          addressed;
    out_item_t   pending_cmds [$];
    int unsigned errors;
    int unsigned edits;
    int unsigned ticks;
    int unsigned busy_ticks;
    int unsigned ignored;
    int unsigned cmds_checked;
    int unsigned writes_checked;

    function new();
      foreach (frame_buf[i]) begin
        frame_buf[i]  = SPACE_CHAR;
        panel_copy[i] = SHOWN_RESET;
      end
      cur_col = '0;
      cur_row = '0;
      scan_c = 0;
      scan_r = 0;
      addressed = 1'b0;
    endfunction

    function int unsigned pending();
      return pending_cmds.size();
    endfunction

    function void queue_cmd(logic kind, int unsigned col, int unsigned row, logic [7:0] ch);
      out_item_t c;
      c.cmd_kind = kind;
      c.cmd_col  = col[3:0];
      c.cmd_row  = row[0];
      c.cmd_char = ch;
      pending_cmds.push_back(c);
    endfunction

    // Clears fill whole rows with spaces and home the cursor.
    function void blank_rows(int unsigned first, int unsigned stop);
      for (int unsigned r = first; r < stop && r < NUM_ROWS; r++) begin
        for (int unsigned c = 0; c < NUM_COLS; c++) begin
          frame_buf[r * NUM_COLS + c] = SPACE_CHAR;
        end
      end
      cur_col = '0;
      cur_row = '0;
    endfunction

    // One refresh step: row wrap, addressing before a dirty run, a write, or skipping a clean cell.
    function void advance_scan();
      int unsigned idx;
      if (scan_c >= NUM_COLS) begin
        scan_c = 0;
        scan_r++;
        if (scan_r >= NUM_ROWS) scan_r = 0;
        queue_cmd(CMD_SET_LOC, scan_c, scan_r, 8'h00);
        return;
      end
      if (scan_r >= NUM_ROWS) scan_r = 0;
      idx = scan_r * NUM_COLS + scan_c;
      if (frame_buf[idx] != panel_copy[idx]) begin
        if (!addressed) begin
          addressed = 1'b1;
          queue_cmd(CMD_SET_LOC, scan_c, scan_r, 8'h00);
          return;
        end
        panel_copy[idx] = frame_buf[idx];
        scan_c++;
        queue_cmd(CMD_WRITE, 0, 0, frame_buf[idx]);
        return;
      end
      addressed = 1'b0;
      scan_c++;
    endfunction

    // Applies one accepted input transaction to the predicted state.
    function void note_item(in_item_t it);
      case (it.func)
        FN_SET_CURSOR: begin
          cur_col = it.pos_x;
          cur_row = it.pos_y;
          edits++;
        end
        FN_PUT_CHAR: begin
          edits++;
          if (cur_col < NUM_COLS && cur_row < NUM_ROWS) begin
            frame_buf[cur_row * NUM_COLS + cur_col] = it.char_code;
            cur_col++;
            if (cur_col == NUM_COLS) begin
              cur_col = '0;
              cur_row++;
              if (cur_row == NUM_ROWS) cur_row = '0;
            end
          end
        end
        FN_CLR_ALL: begin
          blank_rows(0, NUM_ROWS);
          edits++;
        end
        FN_CLR_BUT_FIRST: begin
          blank_rows(1, NUM_ROWS);
          edits++;
        end
        FN_CLR_BUT_LAST: begin
          blank_rows(0, NUM_ROWS - 1);
          edits++;
        end
        FN_REFRESH: begin
          ticks++;
          if (it.lcd_busy) busy_ticks++;
          else advance_scan();
        end
        default: ignored++;
      endcase
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      errors++;
      if (errors <= REPORT_LIMIT)
        $error("panel command %0d: %s expected 0x%0h, got 0x%0h",
               cmds_checked, field, want, got);
    endfunction

    // Compares one accepted panel command with the oldest prediction.
    function void check_command(out_item_t got);
      out_item_t want;
      if (pending_cmds.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $error("unexpected panel command: kind %0b col %0d row %0b char 0x%0h",
                 got.cmd_kind, got.cmd_col, got.cmd_row, got.cmd_char);
        return;
      end
      want = pending_cmds.pop_front();
      if (got.cmd_kind !== want.cmd_kind)
        report("cmd_kind", 32'(want.cmd_kind), 32'(got.cmd_kind));
      if (got.cmd_col !== want.cmd_col)
        report("cmd_col", 32'(want.cmd_col), 32'(got.cmd_col));
      if (got.cmd_row !== want.cmd_row)
        report("cmd_row", 32'(want.cmd_row), 32'(got.cmd_row));
      if (got.cmd_char !== want.cmd_char)
        report("cmd_char", 32'(want.cmd_char), 32'(got.cmd_char));
      if (want.cmd_kind == CMD_WRITE) writes_checked++;
      cmds_checked++;
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  int unsigned holds_requested;
  int unsigned holds_served;
  int unsigned quiet_cycles = 0;

  lcd_cmd_scoreboard sb = new();

  char_lcd_diff_refresh_buffer_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Free-running clock, 10 ns period.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Monitor both channels at the rising edge and watch for a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_item(in_data);
      if (out_valid && out_ready) sb.check_command(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles.", WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Receiver: switches between stall patterns, and serves long hold-off requests.
  initial begin
    rx_pattern_e pattern;
    int unsigned pattern_left;
    int unsigned phase;
    pattern = RX_OPEN;
    pattern_left = 0;
    phase = 0;
    holds_served = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served < holds_requested) begin
        holds_served++;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
      end
      if (pattern_left == 0) begin
        pattern = rx_pattern_e'($urandom_range(0, 3));
        pattern_left = $urandom_range(16, 96);
      end
      pattern_left--;
      phase++;
      case (pattern)
        RX_OPEN:   out_ready <= 1'b1;
        RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
        RX_SPARSE: out_ready <= (phase % 4 == 0);
        default:   out_ready <= ($urandom_range(0, 1) != 0);
      endcase
    end
  end

  function automatic in_item_t make_item(logic [2:0] func, logic [7:0] x, logic [7:0] y,
                                         logic [7:0] ch, logic busy);
    in_item_t it;
    it.func = func;
    it.pos_x = x;
    it.pos_y = y;
    it.char_code = ch;
    it.lcd_busy = busy;
    return it;
  endfunction

  // Mostly edits and idle-panel ticks; a few out-of-range cursors and ignored selectors.
  function automatic in_item_t random_item();
    in_item_t it;
    int unsigned pick;
    it = make_item(FN_REFRESH, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), ($urandom_range(0, 1) != 0));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      it.func = FN_REFRESH;
      it.lcd_busy = ($urandom_range(0, 7) == 0);
    end else if (pick < 76) begin
      it.func = FN_PUT_CHAR;
    end else if (pick < 86) begin
      it.func = FN_SET_CURSOR;
      it.pos_x = 8'($urandom_range(0, NUM_COLS - 1));
      it.pos_y = 8'($urandom_range(0, NUM_ROWS - 1));
    end else if (pick < 90) begin
      it.func = FN_SET_CURSOR;
    end else if (pick < 92) begin
      it.func = FN_CLR_ALL;
    end else if (pick < 94) begin
      it.func = FN_CLR_BUT_FIRST;
    end else if (pick < 96) begin
      it.func = FN_CLR_BUT_LAST;
    end else if (pick < 98) begin
      it.func = FN_UNUSED_LO;
    end else begin
      it.func = FN_UNUSED_HI;
    end
    return it;
  endfunction

  // Offers one transaction and returns at the falling edge after it is taken.
  task automatic send_item(input in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Main sequence: reset, directed cases, random traffic, drain and verdict.
  initial begin
    in_item_t    it;
    int unsigned sent;
    int unsigned burst_left;
    in_valid = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    holds_requested = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Busy tick and unused selectors change nothing.
    send_item(make_item(FN_REFRESH, 8'h00, 8'h00, 8'h00, 1'b1));
    send_item(make_item(FN_UNUSED_LO, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    send_item(make_item(FN_UNUSED_HI, 8'h00, 8'h00, 8'h00, 1'b0));
    // A put char with the cursor far outside the buffer is dropped.
    send_item(make_item(FN_SET_CURSOR, 8'hFF, 8'hFF, 8'h00, 1'b0));
    send_item(make_item(FN_PUT_CHAR, 8'h00, 8'h00, 8'hFF, 1'b0));
    // The last cell wraps the cursor back to the top left corner.
    send_item(make_item(FN_SET_CURSOR, 8'(NUM_COLS - 1), 8'(NUM_ROWS - 1), 8'h00, 1'b0));
    send_item(make_item(FN_PUT_CHAR, 8'h00, 8'h00, 8'h00, 1'b0));
    send_item(make_item(FN_PUT_CHAR, 8'h00, 8'h00, 8'h41, 1'b0));
    send_item(make_item(FN_SET_CURSOR, 8'h00, 8'h01, 8'h00, 1'b0));
    send_item(make_item(FN_PUT_CHAR, 8'hFF, 8'hFF, 8'h5A, 1'b1));
    // The three clears.
    send_item(make_item(FN_CLR_BUT_FIRST, 8'h00, 8'h00, 8'h00, 1'b0));
    send_item(make_item(FN_CLR_BUT_LAST, 8'h00, 8'h00, 8'h00, 1'b0));
    send_item(make_item(FN_CLR_ALL, 8'h00, 8'h00, 8'h00, 1'b0));
    // Column and row just past the edge are both dropped.
    send_item(make_item(FN_SET_CURSOR, 8'(NUM_COLS), 8'h00, 8'h00, 1'b0));
    send_item(make_item(FN_PUT_CHAR, 8'h00, 8'h00, 8'h7E, 1'b0));
    send_item(make_item(FN_SET_CURSOR, 8'h00, 8'(NUM_ROWS), 8'h00, 1'b0));
    send_item(make_item(FN_PUT_CHAR, 8'h00, 8'h00, 8'h7E, 1'b0));
    // Refresh ticks start the repaint of the whole panel.
    repeat (8) send_item(make_item(FN_REFRESH, 8'h00, 8'h00, 8'h00, 1'b0));

    // Random traffic in bursts; two long receiver hold-offs fill the block.
    sent = 0;
    burst_left = 0;
    while (sent < RANDOM_ITEMS) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
      end
      burst_left--;
      if (sent == 400 || sent == 1200) holds_requested++;
      it = random_item();
      send_item(it);
      sent++;
    end
    pause_sender(0);

    // Wait for every predicted command, then keep watching for stray commands.
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d edit transactions and %0d refresh ticks (%0d busy), %0d ignored.",
             sb.edits, sb.ticks, sb.busy_ticks, sb.ignored);
    $display("Checked %0d panel commands, %0d of them character writes.",
             sb.cmds_checked, sb.writes_checked);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/lcdrb_pkg.sv
hw/rtl/lcdrb_frame_mem.sv
hw/rtl/lcdrb_ctrl.sv
hw/rtl/char_lcd_diff_refresh_buffer_core.sv
tb/sv/testbench.sv
